[hw/rtl/crc32c_record_deframer_macros.svh]
// assertion macros shared by the record deframer rtl
`ifndef CRC32C_RECORD_DEFRAMER_MACROS_SVH
`define CRC32C_RECORD_DEFRAMER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define CRCRD_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define CRCRD_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/crcrd_pkg.sv]
// shared types, constants and the crc32c byte update for the record deframer
package crcrd_pkg;

    // header layout: checksum, type word, payload length, 4 bytes each
    localparam int unsigned HDR_BYTES = 4 * 3;
    localparam int unsigned HDR_W     = 8 * HDR_BYTES;
    localparam logic [3:0]  HDR_LAST  = 4'(HDR_BYTES - 1);

    // reflected castagnoli crc
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_END = 2'd1,
        ST_BAD = 2'd2,
        ST_CRC = 2'd3
    } status_t;

    typedef enum logic {
        PH_HEADER  = 1'b0,
        PH_PAYLOAD = 1'b1
    } phase_t;

    // control from the deframer to the crc unit
    typedef struct packed {
        logic init;
        logic update;
    } crc_ctl_t;

    // one byte through the crc register, lsb first
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                                input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/crcrd_crc_unit.sv]
// running crc32c register over the payload bytes
module crcrd_crc_unit
    import crcrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  crc_ctl_t    ctl,
    input  logic [7:0]  data,
    output logic [31:0] crc_upd
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    // value after folding in the current byte
    assign crc_upd = crc32c_byte(crc_reg, data);

    // next register value
    always_comb begin
        crc_next = crc_reg;
        if (ctl.init) begin
            crc_next = CRC_INIT;
        end else if (ctl.update) begin
            crc_next = crc_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

endmodule

[hw/rtl/crc32c_record_deframer.sv]
// Record deframer: splits a byte stream into crc32c-checked, length-prefixed records.
//
// s_ channel: one stream byte per item (s_byte_value), or an end marker
// (s_stream_end = 1, byte ignored). Each record is a 12-byte little-endian
// header (crc32c of payload, type word, payload length) then the payload.
// m_ channel: zero or one item per input item. Payload bytes come out with
// m_has_byte = 1; the last one also has m_record_end = 1 and status ok or
// checksum error. A type mismatch or a length above MAX_RECORD_LEN gives a
// bad-record item after the last header byte; an empty record closes at once.
// cfg channel: writes the expected type word; always ready, write only while idle.
// Path: an accepted item reaches m_ through the input register, then the result
// register. Throughput: one item per cycle; all per-byte work
// (crc32c byte update, length counter, header compare) sits between the two
// registers. When the receiver stalls, the result register holds, then the
// input register fills and s_ready drops; no item is lost.
// Reset (aresetn low, synchronous): both registers empty, header phase,
// crc preset to all ones, type word 0.
`include "crc32c_record_deframer_macros.svh"

module crc32c_record_deframer
    import crcrd_pkg::*;
#(
    parameter int unsigned MAX_RECORD_LEN = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_record_type,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_stream_end,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_has_byte,
    output logic        m_record_end,
    output logic [1:0]  m_status
);

    localparam int unsigned LEFT_W    = $clog2(MAX_RECORD_LEN + 1);
    localparam logic [31:0] MAX_LEN_W = 32'(MAX_RECORD_LEN);

    // input register
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_end_reg;
    // configuration and framing state
    logic [31:0]       record_type_reg;
    phase_t            phase_reg, phase_next;
    logic [3:0]        hdr_count_reg, hdr_count_next;
    logic [HDR_W-1:0]  hdr_reg, hdr_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    // result register
    logic              m_valid_reg;
    logic [7:0]        m_byte_reg;
    logic              m_has_reg;
    logic              m_end_reg;
    logic [1:0]        m_status_reg;

    logic              advance;
    logic [HDR_W-1:0]  hdr_full;
    logic [31:0]       type_word;
    logic [31:0]       len_word;
    logic              hdr_bad;
    logic              last_byte;
    logic [31:0]       crc_upd;
    logic              crc_ok;
    crc_ctl_t          crc_ctl;
    // combinational result
    logic              r_emit;
    logic [7:0]        r_byte;
    logic              r_has;
    logic              r_end;
    status_t           r_status;

    // handshakes
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // header as it stands with the current byte shifted in
    assign hdr_full  = {in_byte_reg, hdr_reg[HDR_W-1:8]};
    assign type_word = hdr_full[63:32];
    assign len_word  = hdr_full[95:64];
    assign hdr_bad   = (type_word != record_type_reg) || (len_word > MAX_LEN_W);
    assign last_byte = (left_reg == LEFT_W'(1));
    assign crc_ok    = ((crc_upd ^ CRC_INIT) == hdr_reg[31:0]);

    crcrd_crc_unit u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (crc_ctl),
        .data    (in_byte_reg),
        .crc_upd (crc_upd)
    );

    // next framing state
    always_comb begin
        phase_next     = phase_reg;
        hdr_count_next = hdr_count_reg;
        hdr_next       = hdr_reg;
        left_next      = left_reg;
        crc_ctl        = '0;
        if (advance) begin
            if (in_end_reg) begin
                phase_next     = PH_HEADER;
                hdr_count_next = 4'd0;
                crc_ctl.init   = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        hdr_next = hdr_full;
                        if (hdr_count_reg == HDR_LAST) begin
                            hdr_count_next = 4'd0;
                            crc_ctl.init   = 1'b1;
                            if (!hdr_bad && (len_word != 32'd0)) begin
                                phase_next = PH_PAYLOAD;
                                left_next  = len_word[LEFT_W-1:0];
                            end
                        end else begin
                            hdr_count_next = hdr_count_reg + 4'd1;
                        end
                    end
                    PH_PAYLOAD: begin
                        crc_ctl.update = 1'b1;
                        left_next      = left_reg - LEFT_W'(1);
                        if (last_byte) begin
                            phase_next = PH_HEADER;
                        end
                    end
                    default: begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    // result for the item in the input register
    always_comb begin
        r_emit   = 1'b0;
        r_byte   = 8'd0;
        r_has    = 1'b0;
        r_end    = 1'b0;
        r_status = ST_OK;
        if (in_end_reg) begin
            r_emit   = 1'b1;
            r_end    = 1'b1;
            r_status = ST_END;
        end else begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (hdr_count_reg == HDR_LAST) begin
                        if (hdr_bad) begin
                            r_emit   = 1'b1;
                            r_end    = 1'b1;
                            r_status = ST_BAD;
                        end else if (len_word == 32'd0) begin
                            r_emit   = 1'b1;
                            r_end    = 1'b1;
                            r_status = (hdr_full[31:0] == 32'd0) ? ST_OK : ST_CRC;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    r_emit = 1'b1;
                    r_byte = in_byte_reg;
                    r_has  = 1'b1;
                    r_end  = last_byte;
                    if (last_byte && !crc_ok) begin
                        r_status = ST_CRC;
                    end
                end
                default: begin
                    r_emit = 1'b0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            phase_reg       <= PH_HEADER;
            hdr_count_reg   <= 4'd0;
            left_reg        <= '0;
            record_type_reg <= 32'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= advance && r_emit;
            end
            phase_reg     <= phase_next;
            hdr_count_reg <= hdr_count_next;
            left_reg      <= left_next;
            if (cfg_valid && cfg_ready) begin
                record_type_reg <= cfg_record_type;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_value;
            in_end_reg  <= s_stream_end;
        end
        hdr_reg <= hdr_next;
        if (advance && r_emit) begin
            m_byte_reg   <= r_byte;
            m_has_reg    <= r_has;
            m_end_reg    <= r_end;
            m_status_reg <= r_status;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_has_byte   = m_has_reg;
    assign m_record_end = m_end_reg;
    assign m_status     = m_status_reg;

    // checks on framing state and results
    `CRCRD_ASSERT_IMP(a_payload_count_zero, aclk, aresetn, phase_reg == PH_PAYLOAD, hdr_count_reg == 4'd0, "header count not cleared in payload phase")
    `CRCRD_ASSERT_IMP(a_payload_left_nonzero, aclk, aresetn, phase_reg == PH_PAYLOAD, left_reg != '0, "payload phase with no bytes left")
    `CRCRD_ASSERT_IMP(a_count_range, aclk, aresetn, 1'b1, hdr_count_reg <= HDR_LAST, "header count past the last header byte")
    `CRCRD_ASSERT_IMP(a_open_item_has_byte, aclk, aresetn, m_valid_reg && !m_end_reg, m_has_reg && (m_status_reg == ST_OK), "non-closing item without a byte or with a status")
    `CRCRD_ASSERT_NXT(a_end_resyncs, aclk, aresetn, advance && in_end_reg, (phase_reg == PH_HEADER) && m_valid_reg && (m_status_reg == ST_END), "stream end did not resync and report")

endmodule
